// ===== sv/ura_pkg.sv =====
// ----------------------------------------------------------------------------
// ura_pkg
// Shared types and constants of the ultrasonic range alarm: event, phase,
// proximity and error codes, register map and the distance scaling constant.
// ----------------------------------------------------------------------------
package ura_pkg;

   localparam int ECHO_BITS  = 16;
   localparam int DIST_BITS  = 14;
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   // distance = floor(count * 343 / 2000) = (count * DIST_MULT) >> DIST_SHIFT,
   // exact for every 16-bit count
   localparam int DIST_MULT_BITS = 25;
   localparam logic [DIST_MULT_BITS-1:0] DIST_MULT = 25'd23018341;
   localparam int DIST_SHIFT = 27;
   localparam int PROD_BITS  = ECHO_BITS + DIST_MULT_BITS;

   localparam logic [DIST_BITS-1:0] DANGER_RESET  = 14'd550;
   localparam logic [DIST_BITS-1:0] WARNING_RESET = 14'd800;

   typedef enum logic [1:0] {
      MODE_ENABLE   = 2'd0,
      MODE_TRIG_END = 2'd1,
      MODE_OVERFLOW = 2'd2,
      MODE_ECHO     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_STOPPED = 2'd0,
      PH_WAITING = 2'd1,
      PH_RUNNING = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      PROX_SAFE    = 2'd0,
      PROX_WARNING = 2'd1,
      PROX_DANGER  = 2'd2
   } prox_type;

   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_BUSY    = 2'd1,
      ERR_INVALID = 2'd2
   } err_type;

   typedef enum logic {
      REG_DANGER  = 1'b0,
      REG_WARNING = 1'b1
   } reg_idx_type;

   // event held in the input register
   typedef struct packed {
      mode_type                mode;
      logic [ECHO_BITS-1:0]    count;
      logic [DIST_BITS-1:0]    dist_mm;
   } item_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] danger_mm;
      logic [DIST_BITS-1:0] warning_mm;
   } thresh_type;

endpackage

// ===== sv/ura_csr.sv =====
// ----------------------------------------------------------------------------
// ura_csr
// Threshold registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module ura_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ura_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [ura_pkg::DATA_BITS-1:0]   pwdata,
   output logic [ura_pkg::DATA_BITS-1:0]   prdata,
   output logic                            pready,
   output ura_pkg::thresh_type             thresh
);

   logic [ura_pkg::DIST_BITS-1:0] danger_ff, danger_in;
   logic [ura_pkg::DIST_BITS-1:0] warning_ff, warning_in;
   ura_pkg::reg_idx_type          idx;
   logic                          wr_en;

   assign pready = 1'b1;
   assign idx    = ura_pkg::reg_idx_type'(paddr[2]);
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      danger_in  = danger_ff;
      warning_in = warning_ff;
      if (wr_en) begin
         unique case (idx)
            ura_pkg::REG_DANGER: begin
               danger_in = pwdata[ura_pkg::DIST_BITS-1:0];
            end
            ura_pkg::REG_WARNING: begin
               warning_in = pwdata[ura_pkg::DIST_BITS-1:0];
            end
            default: begin
               danger_in = danger_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         danger_ff  <= ura_pkg::DANGER_RESET;
         warning_ff <= ura_pkg::WARNING_RESET;
      end else begin
         danger_ff  <= danger_in;
         warning_ff <= warning_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         ura_pkg::REG_DANGER: begin
            prdata[ura_pkg::DIST_BITS-1:0] = danger_ff;
         end
         ura_pkg::REG_WARNING: begin
            prdata[ura_pkg::DIST_BITS-1:0] = warning_ff;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign thresh.danger_mm  = danger_ff;
   assign thresh.warning_mm = warning_ff;

endmodule

// ===== sv/ura_range.sv =====
// ----------------------------------------------------------------------------
// ura_range
// Input register: captures the event and the distance scaled from its count.
// ----------------------------------------------------------------------------
module ura_range #(
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [ura_pkg::ECHO_BITS-1:0]   req_echo_count,
   output logic                            item_valid,
   input  logic                            item_ready,
   output ura_pkg::item_type               item
);

   localparam int UsedBits = (COUNT_BITS < ura_pkg::ECHO_BITS) ? COUNT_BITS
                                                               : ura_pkg::ECHO_BITS;
   localparam logic [ura_pkg::ECHO_BITS-1:0] CountMask =
      ura_pkg::ECHO_BITS'((33'd1 << UsedBits) - 33'd1);

   logic                              valid_ff, valid_in;
   ura_pkg::item_type                 item_ff;
   logic [ura_pkg::ECHO_BITS-1:0]     count;
   logic [ura_pkg::PROD_BITS-1:0]     prod;
   logic                              load;

   assign req_ready = ~valid_ff | item_ready;
   assign load      = req_valid & req_ready;

   assign count = req_echo_count & CountMask;
   assign prod  = ura_pkg::PROD_BITS'(count) * ura_pkg::PROD_BITS'(ura_pkg::DIST_MULT);

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.mode    <= ura_pkg::mode_type'(req_mode);
         item_ff.count   <= count;
         item_ff.dist_mm <= prod[ura_pkg::DIST_SHIFT +: ura_pkg::DIST_BITS];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/ura_ctrl.sv =====
// ----------------------------------------------------------------------------
// ura_ctrl
// Ranging state, threshold classification and the result register.
// ----------------------------------------------------------------------------
module ura_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   output logic                            item_ready,
   input  ura_pkg::item_type               item,
   input  ura_pkg::thresh_type             thresh,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_error_code,
   output logic                            rsp_trigger_level,
   output logic [1:0]                      rsp_phase,
   output logic [ura_pkg::DIST_BITS-1:0]   rsp_distance_mm,
   output logic [ura_pkg::ECHO_BITS-1:0]   rsp_echo_time,
   output logic [1:0]                      rsp_proximity,
   output logic                            rsp_no_echo,
   output logic                            rsp_danger_alert
);

   ura_pkg::phase_type               phase_ff, phase_in;
   logic                             trigger_ff, trigger_in;
   logic [ura_pkg::ECHO_BITS-1:0]    time_ff, time_in;
   logic [ura_pkg::DIST_BITS-1:0]    dist_ff, dist_in;
   ura_pkg::prox_type                prox_ff, prox_in;
   logic                             latched_ff, latched_in;
   logic                             no_echo_ff, no_echo_in;
   ura_pkg::err_type                 err;
   logic                             alert;

   logic                             rsp_valid_ff, rsp_valid_in;
   ura_pkg::err_type                 rsp_err_ff;
   logic                             rsp_alert_ff;
   logic                             take;

   assign item_ready = ~rsp_valid_ff | rsp_ready;
   assign take       = item_valid & item_ready;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (item.mode)
         ura_pkg::MODE_ENABLE: begin
            if (phase_ff == ura_pkg::PH_STOPPED) phase_in = ura_pkg::PH_RUNNING;
         end
         ura_pkg::MODE_TRIG_END: begin
            phase_in = phase_ff;
         end
         ura_pkg::MODE_OVERFLOW: begin
            if (phase_ff == ura_pkg::PH_STOPPED || phase_ff == ura_pkg::PH_RUNNING) begin
               phase_in = ura_pkg::PH_RUNNING;
            end
         end
         ura_pkg::MODE_ECHO: begin
            if (phase_ff == ura_pkg::PH_RUNNING) phase_in = ura_pkg::PH_STOPPED;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // readings, error and alert
   always_comb begin
      err        = ura_pkg::ERR_OK;
      alert      = 1'b0;
      trigger_in = trigger_ff;
      time_in    = time_ff;
      dist_in    = dist_ff;
      prox_in    = prox_ff;
      latched_in = latched_ff;
      no_echo_in = no_echo_ff;
      unique case (item.mode)
         ura_pkg::MODE_ENABLE: begin
            if (phase_ff == ura_pkg::PH_STOPPED) trigger_in = 1'b1;
            else err = ura_pkg::ERR_BUSY;
         end
         ura_pkg::MODE_TRIG_END: begin
            if (phase_ff == ura_pkg::PH_RUNNING) trigger_in = 1'b0;
            else err = ura_pkg::ERR_INVALID;
         end
         ura_pkg::MODE_OVERFLOW: begin
            if (phase_ff == ura_pkg::PH_RUNNING) begin
               no_echo_in = 1'b1;
               time_in    = '1;
               dist_in    = '1;
               trigger_in = 1'b1;
            end else if (phase_ff == ura_pkg::PH_STOPPED) begin
               trigger_in = 1'b1;
            end else begin
               err = ura_pkg::ERR_INVALID;
            end
         end
         ura_pkg::MODE_ECHO: begin
            if (phase_ff == ura_pkg::PH_RUNNING) begin
               trigger_in = 1'b0;
               time_in    = item.count;
               dist_in    = item.dist_mm;
               no_echo_in = 1'b0;
               if (item.dist_mm <= thresh.danger_mm) begin
                  prox_in    = ura_pkg::PROX_DANGER;
                  latched_in = 1'b1;
                  alert      = ~latched_ff;
               end else if (item.dist_mm <= thresh.warning_mm) begin
                  prox_in    = ura_pkg::PROX_WARNING;
                  latched_in = 1'b0;
               end else begin
                  prox_in    = ura_pkg::PROX_SAFE;
                  latched_in = 1'b0;
               end
            end else begin
               err = ura_pkg::ERR_INVALID;
            end
         end
         default: begin
            err = ura_pkg::ERR_INVALID;
         end
      endcase
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= ura_pkg::PH_STOPPED;
         trigger_ff   <= 1'b0;
         time_ff      <= '0;
         dist_ff      <= '0;
         prox_ff      <= ura_pkg::PROX_SAFE;
         latched_ff   <= 1'b0;
         no_echo_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff   <= phase_in;
            trigger_ff <= trigger_in;
            time_ff    <= time_in;
            dist_ff    <= dist_in;
            prox_ff    <= prox_in;
            latched_ff <= latched_in;
            no_echo_ff <= no_echo_in;
         end
      end
   end

   // the state registers already carry the post-event readings; hold the rest
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_err_ff   <= err;
         rsp_alert_ff <= alert;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_error_code    = rsp_err_ff;
   assign rsp_trigger_level = trigger_ff;
   assign rsp_phase         = phase_ff;
   assign rsp_distance_mm   = dist_ff;
   assign rsp_echo_time     = time_ff;
   assign rsp_proximity     = prox_ff;
   assign rsp_no_echo       = no_echo_ff;
   assign rsp_danger_alert  = rsp_alert_ff;

endmodule

// ===== sv/ultrasonic_range_alarm_top.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_range_alarm_top
// Echo-ranging controller with danger/warning classification and alert.
// ----------------------------------------------------------------------------
// Takes one event beat per clock unless stalled (enable, trigger end, timer
// overflow, echo) and returns one result beat for each: the input register
// captures the event and the distance scaled from its count by a constant
// multiplier, and the result register holds the phase, trigger level, last
// readings, classification and a one-shot danger alert. req_ready follows
// rsp_ready combinationally, so a stalled result stops the input only when
// both registers are full. The user must write thresholds through the
// configuration port only while no event is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module ultrasonic_range_alarm_top #(
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [ura_pkg::ECHO_BITS-1:0]   req_echo_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_error_code,
   output logic                            rsp_trigger_level,
   output logic [1:0]                      rsp_phase,
   output logic [ura_pkg::DIST_BITS-1:0]   rsp_distance_mm,
   output logic [ura_pkg::ECHO_BITS-1:0]   rsp_echo_time,
   output logic [1:0]                      rsp_proximity,
   output logic                            rsp_no_echo,
   output logic                            rsp_danger_alert,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ura_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [ura_pkg::DATA_BITS-1:0]   pwdata,
   output logic [ura_pkg::DATA_BITS-1:0]   prdata,
   output logic                            pready
);

   ura_pkg::thresh_type  thresh;
   ura_pkg::item_type    item;
   logic                 item_valid;
   logic                 item_ready;

   ura_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .thresh  (thresh)
   );

   ura_range #(
      .COUNT_BITS (COUNT_BITS)
   ) u_range (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_echo_count (req_echo_count),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item           (item)
   );

   ura_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item_ready        (item_ready),
      .item              (item),
      .thresh            (thresh),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_error_code    (rsp_error_code),
      .rsp_trigger_level (rsp_trigger_level),
      .rsp_phase         (rsp_phase),
      .rsp_distance_mm   (rsp_distance_mm),
      .rsp_echo_time     (rsp_echo_time),
      .rsp_proximity     (rsp_proximity),
      .rsp_no_echo       (rsp_no_echo),
      .rsp_danger_alert  (rsp_danger_alert)
   );

`ifndef SYNTHESIS
   // an alert only comes with a clean danger reading
   a_alert_danger: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_danger_alert |->
         rsp_proximity == ura_pkg::PROX_DANGER && rsp_error_code == ura_pkg::ERR_OK)
      else $error("danger alert without a danger reading");

   // a missed echo forces both readings to all ones
   a_no_echo_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_echo |-> rsp_echo_time == '1 && rsp_distance_mm == '1)
      else $error("no-echo result with live readings");

   // trigger is low whenever ranging is stopped
   a_stopped_trigger: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == ura_pkg::PH_STOPPED |-> !rsp_trigger_level)
      else $error("trigger high while stopped");

   // the result after an accepted alert never carries an alert with an error code
   a_alert_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_danger_alert |=>
         !(rsp_valid && rsp_danger_alert && rsp_error_code != ura_pkg::ERR_OK))
      else $error("alert on an error result");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ultrasonic range alarm. A directed table walks
// the wrong-state events, overflow with and without a running measurement and
// the threshold edges, then random ranging cycles run under several threshold
// settings. Each result beat is compared field by field with its typed row
// or the local ranging model, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int ECHO_BITS = ura_pkg::ECHO_BITS;
   localparam int DIST_BITS = ura_pkg::DIST_BITS;
   localparam int ADDR_BITS = ura_pkg::ADDR_BITS;
   localparam int DATA_BITS = ura_pkg::DATA_BITS;

   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 171;
   localparam int NUM_PHASES   = 6;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD    = 80;
   localparam int MAX_PRINTS   = 50;

   typedef struct packed {
      ura_pkg::err_type       err;
      logic                   trig;
      ura_pkg::phase_type     ph;
      logic [DIST_BITS-1:0]   dist_mm;
      logic [ECHO_BITS-1:0]   etime;
      ura_pkg::prox_type      prox;
      logic                   no_echo;
      logic                   alert;
   } reading_type;

   typedef struct packed {
      ura_pkg::mode_type      mode;
      logic [ECHO_BITS-1:0]   count;
      logic                   typed;
      reading_type            want;
   } event_row_type;

   localparam reading_type UNTYPED = '0;

   // typed rows carry the reading expected straight from the event rules;
   // the rest are left to the range model
   localparam int NUM_DIRECTED = 23;
   localparam event_row_type DIRECTED [NUM_DIRECTED] = '{
      '{ura_pkg::MODE_TRIG_END, 16'h0000, 1'b1,
        '{ura_pkg::ERR_INVALID, 1'b0, ura_pkg::PH_STOPPED, 14'd0, 16'd0,
          ura_pkg::PROX_SAFE, 1'b0, 1'b0}},
      '{ura_pkg::MODE_ECHO,     16'hFFFF, 1'b1,
        '{ura_pkg::ERR_INVALID, 1'b0, ura_pkg::PH_STOPPED, 14'd0, 16'd0,
          ura_pkg::PROX_SAFE, 1'b0, 1'b0}},
      '{ura_pkg::MODE_OVERFLOW, 16'h0000, 1'b1,
        '{ura_pkg::ERR_OK, 1'b1, ura_pkg::PH_RUNNING, 14'd0, 16'd0,
          ura_pkg::PROX_SAFE, 1'b0, 1'b0}},
      '{ura_pkg::MODE_ENABLE,   16'hFFFF, 1'b1,
        '{ura_pkg::ERR_BUSY, 1'b1, ura_pkg::PH_RUNNING, 14'd0, 16'd0,
          ura_pkg::PROX_SAFE, 1'b0, 1'b0}},
      '{ura_pkg::MODE_TRIG_END, 16'hFFFF, 1'b1,
        '{ura_pkg::ERR_OK, 1'b0, ura_pkg::PH_RUNNING, 14'd0, 16'd0,
          ura_pkg::PROX_SAFE, 1'b0, 1'b0}},
      '{ura_pkg::MODE_OVERFLOW, 16'h1234, 1'b1,
        '{ura_pkg::ERR_OK, 1'b1, ura_pkg::PH_RUNNING, 14'h3FFF, 16'hFFFF,
          ura_pkg::PROX_SAFE, 1'b1, 1'b0}},
      '{ura_pkg::MODE_ECHO,     16'h0000, 1'b1,
        '{ura_pkg::ERR_OK, 1'b0, ura_pkg::PH_STOPPED, 14'd0, 16'd0,
          ura_pkg::PROX_DANGER, 1'b0, 1'b1}},
      '{ura_pkg::MODE_ENABLE,   16'h0000, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ECHO,     16'h0000, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ENABLE,   16'h0000, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ECHO,     16'hFFFF, 1'b1,
        '{ura_pkg::ERR_OK, 1'b0, ura_pkg::PH_STOPPED, 14'd11239, 16'hFFFF,
          ura_pkg::PROX_SAFE, 1'b0, 1'b0}},
      '{ura_pkg::MODE_ENABLE,   16'h0000, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ECHO,     16'd3207, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ENABLE,   16'h0000, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ECHO,     16'd3213, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ENABLE,   16'h0000, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ECHO,     16'd4665, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ENABLE,   16'h0000, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ECHO,     16'd4671, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ENABLE,   16'h0000, 1'b0, UNTYPED},
      '{ura_pkg::MODE_OVERFLOW, 16'hAAAA, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ECHO,     16'h5555, 1'b0, UNTYPED},
      '{ura_pkg::MODE_ECHO,     16'hAAAA, 1'b0, UNTYPED}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [1:0]              req_mode;
   logic [ECHO_BITS-1:0]    req_echo_count;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [1:0]              rsp_error_code;
   logic                    rsp_trigger_level;
   logic [1:0]              rsp_phase;
   logic [DIST_BITS-1:0]    rsp_distance_mm;
   logic [ECHO_BITS-1:0]    rsp_echo_time;
   logic [1:0]              rsp_proximity;
   logic                    rsp_no_echo;
   logic                    rsp_danger_alert;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [ADDR_BITS-1:0]    paddr;
   logic [DATA_BITS-1:0]    pwdata;
   logic [DATA_BITS-1:0]    prdata;
   logic                    pready;

   // range model state
   ura_pkg::phase_type      ph_q       = ura_pkg::PH_STOPPED;
   logic                    trig_q     = 1'b0;
   logic [ECHO_BITS-1:0]    time_q     = '0;
   logic [DIST_BITS-1:0]    dist_q     = '0;
   ura_pkg::prox_type       prox_q     = ura_pkg::PROX_SAFE;
   logic                    latch_q    = 1'b0;
   logic                    no_echo_q  = 1'b0;
   logic [DIST_BITS-1:0]    danger_thr  = ura_pkg::DANGER_RESET;
   logic [DIST_BITS-1:0]    warning_thr = ura_pkg::WARNING_RESET;

   reading_type             pending_readings [$];
   int                      mismatch_count = 0;
   int                      results_seen   = 0;
   int                      events_sent    = 0;
   int                      idle_cycles    = 0;
   bit                      quiet          = 1'b0;

   ultrasonic_range_alarm_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_echo_count    (req_echo_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_error_code    (rsp_error_code),
      .rsp_trigger_level (rsp_trigger_level),
      .rsp_phase         (rsp_phase),
      .rsp_distance_mm   (rsp_distance_mm),
      .rsp_echo_time     (rsp_echo_time),
      .rsp_proximity     (rsp_proximity),
      .rsp_no_echo       (rsp_no_echo),
      .rsp_danger_alert  (rsp_danger_alert),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // advance the range model by one event and return the reading it gives
   function automatic reading_type compute_reading(input ura_pkg::mode_type m,
                                                   input logic [ECHO_BITS-1:0] cnt);
      reading_type r;
      int unsigned mm;
      r       = '0;
      r.err   = ura_pkg::ERR_OK;
      mm      = (int'(cnt) * 343) / 2000;
      case (m)
         ura_pkg::MODE_ENABLE: begin
            if (ph_q == ura_pkg::PH_STOPPED) begin
               ph_q   = ura_pkg::PH_RUNNING;
               trig_q = 1'b1;
            end else begin
               r.err = ura_pkg::ERR_BUSY;
            end
         end
         ura_pkg::MODE_TRIG_END: begin
            if (ph_q == ura_pkg::PH_RUNNING) trig_q = 1'b0;
            else r.err = ura_pkg::ERR_INVALID;
         end
         ura_pkg::MODE_OVERFLOW: begin
            if (ph_q == ura_pkg::PH_RUNNING) begin
               no_echo_q = 1'b1;
               time_q    = '1;
               dist_q    = '1;
               trig_q    = 1'b1;
            end else if (ph_q == ura_pkg::PH_STOPPED) begin
               ph_q   = ura_pkg::PH_RUNNING;
               trig_q = 1'b1;
            end else begin
               r.err = ura_pkg::ERR_INVALID;
            end
         end
         default: begin
            if (ph_q == ura_pkg::PH_RUNNING) begin
               ph_q      = ura_pkg::PH_STOPPED;
               trig_q    = 1'b0;
               time_q    = cnt;
               dist_q    = DIST_BITS'(mm);
               no_echo_q = 1'b0;
               if (dist_q <= danger_thr) begin
                  prox_q = ura_pkg::PROX_DANGER;
                  if (!latch_q) begin
                     latch_q = 1'b1;
                     r.alert = 1'b1;
                  end
               end else if (dist_q <= warning_thr) begin
                  prox_q  = ura_pkg::PROX_WARNING;
                  latch_q = 1'b0;
               end else begin
                  prox_q  = ura_pkg::PROX_SAFE;
                  latch_q = 1'b0;
               end
            end else begin
               r.err = ura_pkg::ERR_INVALID;
            end
         end
      endcase
      r.trig    = trig_q;
      r.ph      = ph_q;
      r.dist_mm = dist_q;
      r.etime   = time_q;
      r.prox    = prox_q;
      r.no_echo = no_echo_q;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < MAX_PRINTS)
         $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_reading(input reading_type want);
      if (rsp_error_code !== want.err) flag_mismatch("error_code", rsp_error_code, want.err);
      if (rsp_trigger_level !== want.trig)
         flag_mismatch("trigger_level", rsp_trigger_level, want.trig);
      if (rsp_phase !== want.ph) flag_mismatch("phase", rsp_phase, want.ph);
      if (rsp_distance_mm !== want.dist_mm)
         flag_mismatch("distance_mm", rsp_distance_mm, want.dist_mm);
      if (rsp_echo_time !== want.etime) flag_mismatch("echo_time", rsp_echo_time, want.etime);
      if (rsp_proximity !== want.prox) flag_mismatch("proximity", rsp_proximity, want.prox);
      if (rsp_no_echo !== want.no_echo) flag_mismatch("no_echo", rsp_no_echo, want.no_echo);
      if (rsp_danger_alert !== want.alert)
         flag_mismatch("danger_alert", rsp_danger_alert, want.alert);
   endtask

   // hold the beat until accepted, then log what the model expects back
   task automatic offer_event(input ura_pkg::mode_type m, input logic [ECHO_BITS-1:0] cnt,
                              input logic typed, input reading_type want);
      reading_type predicted;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_echo_count <= cnt;
      do @(posedge clock); while (!req_ready);
      predicted = compute_reading(m, cnt);
      pending_readings.push_back(typed ? want : predicted);
      events_sent++;
   endtask

   task automatic sender_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = 0;
      if (!quiet)
         n = (r < 55) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input ura_pkg::reg_idx_type idx,
                             input logic [DATA_BITS-1:0] wdata,
                             output logic [DATA_BITS-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= ADDR_BITS'({idx, 2'b00});
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_thresholds(input logic [DIST_BITS-1:0] dng,
                                 input logic [DIST_BITS-1:0] wrn);
      logic [DATA_BITS-1:0] rd;
      csr_access(1'b1, ura_pkg::REG_DANGER, DATA_BITS'(dng), rd);
      csr_access(1'b1, ura_pkg::REG_WARNING, DATA_BITS'(wrn), rd);
      danger_thr  = dng;
      warning_thr = wrn;
      csr_access(1'b0, ura_pkg::REG_DANGER, '0, rd);
      if (rd !== DATA_BITS'(dng)) flag_mismatch("danger_mm readback", rd, dng);
      csr_access(1'b0, ura_pkg::REG_WARNING, '0, rd);
      if (rd !== DATA_BITS'(wrn)) flag_mismatch("warning_mm readback", rd, wrn);
   endtask

   // counts clustered around the two thresholds, plus the full range
   function automatic logic [ECHO_BITS-1:0] pick_echo_count();
      int r;
      int base;
      r = $urandom_range(0, 99);
      if (r < 40) return ECHO_BITS'($urandom);
      if (r >= 90) return (r < 95) ? ECHO_BITS'($urandom_range(0, 60)) : '1;
      base = ((r < 65) ? int'(danger_thr) : int'(warning_thr)) * 2000 / 343;
      base = base + int'($urandom_range(0, 16)) - 8;
      if (base < 0) base = 0;
      if (base > 65535) base = 65535;
      return ECHO_BITS'(base);
   endfunction

   task automatic offer_and_gap(input ura_pkg::mode_type m,
                                input logic [ECHO_BITS-1:0] cnt);
      offer_event(m, cnt, 1'b0, UNTYPED);
      sender_gap();
   endtask

   // mostly well-formed measurement cycles, some stray events in between
   task automatic random_cycle();
      if ($urandom_range(0, 99) < 15) begin
         offer_and_gap(ura_pkg::mode_type'($urandom_range(0, 3)), ECHO_BITS'($urandom));
      end else begin
         if (ph_q != ura_pkg::PH_RUNNING)
            offer_and_gap(($urandom_range(0, 4) == 0) ? ura_pkg::MODE_OVERFLOW
                                                      : ura_pkg::MODE_ENABLE,
                          ECHO_BITS'($urandom));
         if ($urandom_range(0, 9) < 7)
            offer_and_gap(ura_pkg::MODE_TRIG_END, ECHO_BITS'($urandom));
         if ($urandom_range(0, 9) < 2)
            offer_and_gap(ura_pkg::MODE_OVERFLOW, ECHO_BITS'($urandom));
         if ($urandom_range(0, 9) < 9) offer_and_gap(ura_pkg::MODE_ECHO, pick_echo_count());
      end
   endtask

   // result side: random stalls, and one long hold-off so the input backs up
   initial begin : result_sink
      int stall_left;
      int r;
      bit long_done;
      stall_left = 0;
      long_done  = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_done && results_seen >= 300) begin
            long_done  = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (!quiet)
               stall_left = (r < 70) ? 0 : (r < 97) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_readings.size() == 0) flag_mismatch("unexpected result beat", 1, 0);
         else check_reading(pending_readings.pop_front());
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[ultrasonic_range_alarm_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int target;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = ura_pkg::MODE_ENABLE;
      req_echo_count = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         offer_event(DIRECTED[i].mode, DIRECTED[i].count, DIRECTED[i].typed,
                     DIRECTED[i].want);
         sender_gap();
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         case (p)
            0: set_thresholds('0, '0);
            1: set_thresholds('1, '1);
            2: set_thresholds(ura_pkg::DANGER_RESET, ura_pkg::WARNING_RESET);
            3: set_thresholds(14'd1200, 14'd300);
            4: set_thresholds(DIST_BITS'($urandom_range(0, 3000)),
                              DIST_BITS'($urandom_range(0, 3000)));
            default: set_thresholds(DIST_BITS'($urandom), DIST_BITS'($urandom));
         endcase
         // one phase runs flat out on both sides
         quiet  = (p == 2);
         target = events_sent + PHASE_ITEMS;
         while (events_sent < target) random_cycle();
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("[ultrasonic_range_alarm_top] OK");
      end else begin
         $display("[ultrasonic_range_alarm_top] ERROR");
      end
      $finish;
   end

endmodule
